@@ rtl/core/rational_arith_unit_defines.svh @@
// Assertion macros used by rau_ctrl
`ifndef RATIONAL_ARITH_UNIT_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define RAU_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define RAU_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition");
`else
`define RAU_ASSERT(lbl, clk, rst_n, prop)
`define RAU_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

@@ rtl/core/rau_pkg.sv @@
package rau_pkg;

	localparam int OPW = 32;

	localparam logic [2:0] CMD_ADD  = 3'd0;
	localparam logic [2:0] CMD_SUB  = 3'd1;
	localparam logic [2:0] CMD_MUL  = 3'd2;
	localparam logic [2:0] CMD_DIV  = 3'd3;
	localparam logic [2:0] CMD_CMP  = 3'd4;
	localparam logic [2:0] CMD_MAKE = 3'd5;
	localparam logic [2:0] CMD_INC  = 3'd6;
	localparam logic [2:0] CMD_NEG  = 3'd7;

	// product slots, in multiplier order
	localparam logic [1:0] PR_AN_BD = 2'd0;
	localparam logic [1:0] PR_BN_AD = 2'd1;
	localparam logic [1:0] PR_AD_BD = 2'd2;
	localparam logic [1:0] PR_AN_BN = 2'd3;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
	} rau_req_t;

	typedef struct packed {
		logic signed [63:0] res_num;
		logic signed [63:0] res_den;
		logic               zero_den_error;
		logic               is_equal;
		logic               is_greater;
		logic               is_less;
	} rau_rsp_t;

	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       sum_en;
		logic       chk_en;
		logic       gcd_init;
		logic       gcd_step;
		logic       div_init;
		logic       div_step;
		logic       wb_en;
		logic       out_load;
	} rau_ctl_t;

	typedef struct packed {
		logic short_path;
		logic gcd_done;
	} rau_sts_t;

	// low OPW bits, sign-extended
	function automatic logic signed [31:0] sx(input logic [31:0] v);
		return 32'(signed'(v[OPW-1:0]));
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(32'd0 - v) : v;
	endfunction

endpackage

@@ rtl/core/rau_req_if.sv @@
interface rau_req_if;
	logic              valid;
	logic              ready;
	rau_pkg::rau_req_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/rau_rsp_if.sv @@
interface rau_rsp_if;
	logic              valid;
	logic              ready;
	rau_pkg::rau_rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/rau_datapath.sv @@
module rau_datapath (
	input  logic              clk,
	input  rau_pkg::rau_req_t req_data,
	input  rau_pkg::rau_ctl_t ctl,
	output rau_pkg::rau_sts_t sts,
	output rau_pkg::rau_rsp_t rsp_data
);

	logic [2:0]         cmd_q;
	logic signed [31:0] an_q, ad_q;
	logic [31:0]        an_m_q, ad_m_q, bn_m_q, bd_m_q;
	logic               s_an_q, s_ad_q, s_bn_q, s_bd_q;
	logic [63:0]        p_anbd_q, p_bnad_q, p_adbd_q, p_anbn_q;
	logic [63:0]        nm_q, dm_q;
	logic               nneg_q, dneg_q;
	logic [63:0]        x_q, y_q, g_q;
	logic [5:0]         k_q;
	logic [64:0]        rn_q, rd_q;
	logic [63:0]        qn_q, qd_q;
	rau_pkg::rau_rsp_t  res_q, out_q;

	logic [31:0]        ma, mb;
	logic [63:0]        prod;
	logic               t1n, t2n, sneg;
	logic [63:0]        smag;
	logic [63:0]        nm_d, dm_d;
	logic               nneg_d, dneg_d;
	logic signed [31:0] ld_an, ld_ad, ld_bn, ld_bd;
	logic signed [63:0] cp, cq;
	logic               flip;
	rau_pkg::rau_rsp_t  direct;
	rau_pkg::rau_rsp_t  wb_res;
	logic [64:0]        rn_n, rd_n;
	logic               bn_n, bd_n;

	// one restoring-division step, shared by both quotients
	function automatic logic [65:0] dstep(input logic [64:0] r, input logic msb,
	                                      input logic [63:0] g);
		logic [64:0] t;
		t = {r[63:0], msb};
		if (t >= {1'b0, g})
			return {1'b1, t - {1'b0, g}};
		return {1'b0, t};
	endfunction

	assign ld_an = rau_pkg::sx(req_data.a_num);
	assign ld_ad = rau_pkg::sx(req_data.a_den);
	assign ld_bn = rau_pkg::sx(req_data.b_num);
	assign ld_bd = rau_pkg::sx(req_data.b_den);

	always_comb begin
		case (ctl.mul_sel)
			rau_pkg::PR_AN_BD: begin ma = an_m_q; mb = bd_m_q; end
			rau_pkg::PR_BN_AD: begin ma = bn_m_q; mb = ad_m_q; end
			rau_pkg::PR_AD_BD: begin ma = ad_m_q; mb = bd_m_q; end
			default:           begin ma = an_m_q; mb = bn_m_q; end
		endcase
	end
	assign prod = 64'(ma) * 64'(mb);

	// signed-magnitude sum of the two cross products
	always_comb begin
		t1n = s_an_q ^ s_bd_q;
		t2n = s_bn_q ^ s_ad_q ^ (cmd_q == rau_pkg::CMD_SUB);
		if (t1n == t2n) begin
			smag = p_anbd_q + p_bnad_q;
			sneg = t1n;
		end else if (p_anbd_q >= p_bnad_q) begin
			smag = p_anbd_q - p_bnad_q;
			sneg = t1n;
		end else begin
			smag = p_bnad_q - p_anbd_q;
			sneg = t2n;
		end
	end

	always_comb begin
		nm_d   = '0;
		dm_d   = '0;
		nneg_d = 1'b0;
		dneg_d = 1'b0;
		case (cmd_q)
			rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
				nm_d = smag;     nneg_d = sneg;
				dm_d = p_adbd_q; dneg_d = s_ad_q ^ s_bd_q;
			end
			rau_pkg::CMD_MUL: begin
				nm_d = p_anbn_q; nneg_d = s_an_q ^ s_bn_q;
				dm_d = p_adbd_q; dneg_d = s_ad_q ^ s_bd_q;
			end
			rau_pkg::CMD_DIV: begin
				nm_d = p_anbd_q; nneg_d = s_an_q ^ s_bd_q;
				dm_d = p_bnad_q; dneg_d = s_ad_q ^ s_bn_q;
			end
			rau_pkg::CMD_MAKE: begin
				nm_d = 64'(an_m_q); nneg_d = s_an_q;
				dm_d = 64'(ad_m_q); dneg_d = s_ad_q;
			end
			default: ;
		endcase
	end

	// results that need no reduction
	always_comb begin
		direct = '0;
		cp     = (s_an_q ^ s_bd_q) ? -$signed(p_anbd_q) : $signed(p_anbd_q);
		cq     = (s_ad_q ^ s_bn_q) ? -$signed(p_bnad_q) : $signed(p_bnad_q);
		flip   = s_ad_q ^ s_bd_q;
		case (cmd_q)
			rau_pkg::CMD_CMP: begin
				direct.is_equal   = (cp == cq);
				direct.is_greater = flip ? (cp < cq) : (cp > cq);
				direct.is_less    = flip ? (cp > cq) : (cp < cq);
			end
			rau_pkg::CMD_INC: begin
				if (ad_m_q == '0) begin
					direct.zero_den_error = 1'b1;
				end else begin
					direct.res_num = 64'(an_q) + 64'(ad_q);
					direct.res_den = 64'(ad_q);
				end
			end
			rau_pkg::CMD_NEG: begin
				if (ad_m_q == '0) begin
					direct.zero_den_error = 1'b1;
				end else begin
					direct.res_num = -64'(an_q);
					direct.res_den = 64'(ad_q);
				end
			end
			default: begin
				if (dm_q == '0)
					direct.zero_den_error = 1'b1;
				else if (nm_q == '0)
					direct.res_den = dm_q;
			end
		endcase
	end

	always_comb begin
		wb_res         = '0;
		wb_res.res_num = (nneg_q ^ dneg_q) ? -qn_q : qn_q;
		wb_res.res_den = qd_q;
	end

	assign sts.short_path = (cmd_q == rau_pkg::CMD_CMP) || (cmd_q == rau_pkg::CMD_INC) ||
	                        (cmd_q == rau_pkg::CMD_NEG) || (nm_q == '0) || (dm_q == '0);
	assign sts.gcd_done   = (y_q == '0);

	assign {bn_n, rn_n} = dstep(rn_q, qn_q[63], g_q);
	assign {bd_n, rd_n} = dstep(rd_q, qd_q[63], g_q);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= req_data.cmd;
			an_q   <= ld_an;
			ad_q   <= ld_ad;
			an_m_q <= rau_pkg::mag32(ld_an);
			ad_m_q <= rau_pkg::mag32(ld_ad);
			bn_m_q <= rau_pkg::mag32(ld_bn);
			bd_m_q <= rau_pkg::mag32(ld_bd);
			s_an_q <= ld_an[31];
			s_ad_q <= ld_ad[31];
			s_bn_q <= ld_bn[31];
			s_bd_q <= ld_bd[31];
		end
		if (ctl.mul_en) begin
			case (ctl.mul_sel)
				rau_pkg::PR_AN_BD: p_anbd_q <= prod;
				rau_pkg::PR_BN_AD: p_bnad_q <= prod;
				rau_pkg::PR_AD_BD: p_adbd_q <= prod;
				default:           p_anbn_q <= prod;
			endcase
		end
		if (ctl.sum_en) begin
			nm_q   <= nm_d;
			dm_q   <= dm_d;
			nneg_q <= nneg_d;
			dneg_q <= dneg_d;
		end
		if (ctl.chk_en)
			res_q <= direct;
		// binary GCD: shift out common twos, then odd-odd subtract
		if (ctl.gcd_init) begin
			x_q <= nm_q;
			y_q <= dm_q;
			k_q <= '0;
		end else if (ctl.gcd_step) begin
			if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + 6'd1;
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_q >= y_q) begin
				x_q <= y_q;
				y_q <= x_q - y_q;
			end else begin
				y_q <= y_q - x_q;
			end
		end
		if (ctl.div_init) begin
			g_q  <= x_q << k_q;
			rn_q <= '0;
			rd_q <= '0;
			qn_q <= nm_q;
			qd_q <= dm_q;
		end else if (ctl.div_step) begin
			rn_q <= rn_n;
			rd_q <= rd_n;
			qn_q <= {qn_q[62:0], bn_n};
			qd_q <= {qd_q[62:0], bd_n};
		end
		if (ctl.wb_en)
			res_q <= wb_res;
		if (ctl.out_load)
			out_q <= res_q;
	end

	assign rsp_data = out_q;

endmodule

@@ rtl/core/rau_ctrl.sv @@
`include "rational_arith_unit_defines.svh"

module rau_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  rau_pkg::rau_sts_t sts,
	output rau_pkg::rau_ctl_t ctl
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_GCD  = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_WB   = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	logic [2:0] state_q, state_d;
	logic [5:0] cnt_q;
	logic       ov_q;

	always_comb begin
		ctl       = '0;
		state_d   = state_q;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = cnt_q[1:0];
				if (cnt_q[1:0] == rau_pkg::PR_AN_BN)
					state_d = ST_SUM;
			end
			ST_SUM: begin
				ctl.sum_en = 1'b1;
				state_d    = ST_CHK;
			end
			ST_CHK: begin
				ctl.chk_en = 1'b1;
				if (sts.short_path) begin
					state_d = ST_FIN;
				end else begin
					ctl.gcd_init = 1'b1;
					state_d      = ST_GCD;
				end
			end
			ST_GCD: begin
				if (sts.gcd_done) begin
					ctl.div_init = 1'b1;
					state_d      = ST_DIV;
				end else begin
					ctl.gcd_step = 1'b1;
				end
			end
			ST_DIV: begin
				ctl.div_step = 1'b1;
				if (cnt_q == 6'd63)
					state_d = ST_WB;
			end
			ST_WB: begin
				ctl.wb_en = 1'b1;
				state_d   = ST_FIN;
			end
			ST_FIN: begin
				if (!ov_q || rsp_ready) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q)
				cnt_q <= '0;
			else if (state_q == ST_MUL || state_q == ST_DIV)
				cnt_q <= cnt_q + 6'd1;
			if (ctl.out_load)
				ov_q <= 1'b1;
			else if (rsp_ready)
				ov_q <= 1'b0;
		end
	end

	assign rsp_valid = ov_q;

	`RAU_ASSERT(a_no_overwrite, clk, arst_n, ctl.out_load |-> (!ov_q || rsp_ready))
	`RAU_ASSERT(a_div_len, clk, arst_n, (state_q == ST_DIV && cnt_q == 6'd63) |=> (state_q == ST_WB))
	`RAU_ASSERT(a_accept, clk, arst_n, (req_valid && req_ready) |=> (state_q == ST_MUL && cnt_q == 6'd0))
	`RAU_ASSERT_NEVER(a_gcd_div, clk, arst_n, ctl.gcd_step && ctl.div_init)

endmodule

@@ rtl/core/rational_arith_unit.sv @@
// Exact fraction arithmetic, one request at a time. A request is taken only
// while the unit is idle; a finished result sits in an output register, so
// a new request can be taken while that result waits. Compare, increment,
// negate and any result with a zero numerator or denominator pass through
// the accepting cycle, the shared 32x32 multiplier that forms the four products
// in turn, then the sum, a check and the output load. Reduced results
// add a binary GCD (one shift or subtract on 64-bit values per cycle), a
// restoring division that makes both quotients at once and a write-back.
module rational_arith_unit (
	input logic        clk,
	input logic        arst_n,
	rau_req_if.sink    req,
	rau_rsp_if.source  rsp
);

	rau_pkg::rau_ctl_t ctl;
	rau_pkg::rau_sts_t sts;

	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	rau_datapath u_datapath (
		.clk      (clk),
		.req_data (req.data),
		.ctl      (ctl),
		.sts      (sts),
		.rsp_data (rsp.data)
	);

endmodule
